// File: src/assert_macros.svh
// Assertion macros used by the top-level RTL file of the dispatch layout counter.
// Each macro builds one labeled concurrent assertion that reports through $error.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition implies the property in the same cycle.
`define MDLC_ASSERT_IMP(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("dispatch layout counter: assertion failed");

// The condition implies the property in the next cycle.
`define MDLC_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("dispatch layout counter: assertion failed");

`endif

// File: src/mdlc_pkg.sv
// Shared types, codes and widths of the dispatch layout counter.
// No dependencies; the interfaces, the RTL modules and the testbench import this package.
package mdlc_pkg;

    // Default sizes handed to the top level parameters.
    localparam int DEF_MAX_EXPERTS = 256;
    localparam int DEF_MAX_RANKS   = 16;
    localparam int DEF_COUNT_BITS  = 16;

    // Fixed field widths of the channels.
    localparam int CMD_W    = 2;
    localparam int CHOICE_W = 9;
    localparam int IDX_W    = 8;
    localparam int KIND_W   = 2;
    localparam int ORD_W    = 16;
    localparam int MASK_W   = 16;
    localparam int CNT_W    = 16;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;
    localparam int RANKS_W    = 5;
    localparam int EXPERTS_W  = 9;

    localparam logic [CFG_IDX_W-1:0] CFG_RANKS_IN_USE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EXPERTS_IN_USE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EXPERTS_PER_RK = 2'd2;

    // Depth of the queue between front and back.
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_ROUTE       = 2'd0,
        CMD_READ_EXPERT = 2'd1,
        CMD_READ_RANK   = 2'd2,
        CMD_CLEAR       = 2'd3
    } mdlc_cmd_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_MASK   = 2'd0,
        KIND_EXPERT = 2'd1,
        KIND_RANK   = 2'd2
    } mdlc_kind_t;

    // A classified operation handed from front to back.
    // For a route, index is the owning rank; for a read, the requested index.
    typedef struct packed {
        mdlc_cmd_t        cmd;
        logic             apply;
        logic             err;
        logic             last;
        logic [IDX_W-1:0] expert;
        logic [IDX_W-1:0] index;
    } mdlc_op_t;

    // Status of the back part.
    typedef struct packed {
        logic sweeping;
        logic stalled;
    } mdlc_status_t;

endpackage

// File: src/mdlc_if.sv
// Valid/ready channel interfaces for input items and result items.
// Depends on mdlc_pkg for the field widths.
interface mdlc_in_if;
    import mdlc_pkg::*;

    logic                       valid;
    logic                       ready;
    logic [CMD_W-1:0]           cmd;
    logic signed [CHOICE_W-1:0] expert_choice;
    logic                       last_of_token;
    logic [IDX_W-1:0]           read_index;

    modport source (
        output valid, cmd, expert_choice, last_of_token, read_index,
        input  ready
    );
    modport sink (
        input  valid, cmd, expert_choice, last_of_token, read_index,
        output ready
    );
endinterface

interface mdlc_out_if;
    import mdlc_pkg::*;

    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] result_kind;
    logic [ORD_W-1:0]  token_ordinal;
    logic [MASK_W-1:0] rank_mask;
    logic [CNT_W-1:0]  count_value;
    logic              bad_index;

    modport source (
        output valid, result_kind, token_ordinal, rank_mask, count_value, bad_index,
        input  ready
    );
    modport sink (
        input  valid, result_kind, token_ordinal, rank_mask, count_value, bad_index,
        output ready
    );
endinterface

// File: src/mdlc_queue.sv
// Short queue of classified operations between the front and the back.
// Depends on mdlc_pkg for the operation type and the depth.
module mdlc_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push_valid,
    output logic               push_ready,
    input  mdlc_pkg::mdlc_op_t push_op,
    output logic               pop_valid,
    input  logic               pop_ready,
    output mdlc_pkg::mdlc_op_t pop_op
);
    import mdlc_pkg::*;

    localparam int PTR_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int LEVEL_W = $clog2(QUEUE_DEPTH + 1);

    mdlc_op_t            slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg;
    logic [PTR_W-1:0]    rd_ptr_reg;
    logic [LEVEL_W-1:0]  level_reg;
    logic                do_push;
    logic                do_pop;

    assign push_ready = (level_reg != LEVEL_W'(QUEUE_DEPTH));
    assign pop_valid  = (level_reg != '0);
    assign pop_op     = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Pointers and fill level.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                      : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                      : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                level_reg <= level_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                level_reg <= level_reg - 1'b1;
            end
        end
    end

    // Queue slots hold payload only.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_op;
        end
    end

endmodule

// File: src/mdlc_front.sv
// Front part: holds the configuration, accepts input beats and classifies them.
// A non-negative route choice goes through an eight-step restoring divider to find its rank.
// Depends on mdlc_pkg and mdlc_in_if.
module mdlc_front #(
    parameter int MAX_EXPERTS = mdlc_pkg::DEF_MAX_EXPERTS,
    parameter int MAX_RANKS   = mdlc_pkg::DEF_MAX_RANKS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    mdlc_in_if.sink                           items,
    input  logic                              cfg_we,
    input  logic [mdlc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [mdlc_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  mdlc_pkg::mdlc_status_t            status,
    output logic                              op_valid,
    input  logic                              op_ready,
    output mdlc_pkg::mdlc_op_t                op
);
    import mdlc_pkg::*;

    localparam int DIV_STEPS = IDX_W;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    typedef enum logic [2:0] {
        F_IDLE = 3'b001,
        F_DIV  = 3'b010,
        F_PUSH = 3'b100
    } front_state_t;

    front_state_t           state_reg;
    front_state_t           state_next;
    logic [RANKS_W-1:0]     ranks_reg;
    logic [EXPERTS_W-1:0]   experts_reg;
    logic [EXPERTS_W-1:0]   per_rank_reg;
    logic [STEP_W-1:0]      step_reg;
    logic [IDX_W-1:0]       num_reg;
    logic [IDX_W-1:0]       rem_reg;
    mdlc_op_t               op_reg;

    mdlc_cmd_t              cmd_in;
    mdlc_op_t               direct_op;
    logic                   is_direct;
    logic                   take_ok;
    logic                   accept;
    logic [EXPERTS_W-1:0]   divisor;
    logic [IDX_W:0]         trial;
    logic                   fits;
    logic [IDX_W:0]         rem_new;
    logic [IDX_W-1:0]       quot;
    logic                   last_step;
    logic                   div_err;

    assign cmd_in  = mdlc_cmd_t'(items.cmd);
    assign take_ok = (state_reg == F_IDLE) && op_ready && !status.sweeping;
    assign accept  = items.valid && take_ok;
    assign items.ready = take_ok;

    // Classify beats that need no division; they go straight to the queue.
    always_comb
    begin
        direct_op        = '0;
        direct_op.cmd    = cmd_in;
        direct_op.last   = items.last_of_token;
        direct_op.index  = items.read_index;
        is_direct        = 1'b1;
        unique case (cmd_in)
            CMD_ROUTE:
            begin
                // A negative choice carries no expert but may still end the token.
                if (!items.expert_choice[CHOICE_W-1])
                begin
                    is_direct = 1'b0;
                end
            end
            CMD_READ_EXPERT:
            begin
                direct_op.err = !(({1'b0, items.read_index} < experts_reg) &&
                                  (32'(items.read_index) < 32'(MAX_EXPERTS)));
            end
            CMD_READ_RANK:
            begin
                direct_op.err = !(({1'b0, items.read_index} < {4'b0, ranks_reg}) &&
                                  (32'(items.read_index) < 32'(MAX_RANKS)));
            end
            CMD_CLEAR:
            begin
            end
        endcase
    end

    // One restoring division step per cycle; a zero divisor counts as one.
    assign divisor   = (per_rank_reg == '0) ? EXPERTS_W'(1) : per_rank_reg;
    assign trial     = {rem_reg, num_reg[IDX_W-1]};
    assign fits      = (trial >= divisor);
    assign rem_new   = fits ? (trial - divisor) : trial;
    assign quot      = {num_reg[IDX_W-2:0], fits};
    assign last_step = (step_reg == STEP_W'(DIV_STEPS - 1));
    assign div_err   = ({1'b0, op_reg.expert} >= experts_reg) ||
                       (32'(op_reg.expert) >= 32'(MAX_EXPERTS)) ||
                       ({1'b0, quot} >= {4'b0, ranks_reg}) ||
                       (32'(quot) >= 32'(MAX_RANKS));

    // Queue handshake.
    assign op_valid = (state_reg == F_PUSH) || ((state_reg == F_IDLE) && accept && is_direct);
    assign op       = (state_reg == F_PUSH) ? op_reg : direct_op;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            F_IDLE:
            begin
                if (accept && !is_direct)
                begin
                    state_next = F_DIV;
                end
            end
            F_DIV:
            begin
                if (last_step)
                begin
                    state_next = F_PUSH;
                end
            end
            F_PUSH:
            begin
                if (op_ready)
                begin
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    // Control state and configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= F_IDLE;
            step_reg     <= '0;
            ranks_reg    <= RANKS_W'(1);
            experts_reg  <= EXPERTS_W'(1);
            per_rank_reg <= EXPERTS_W'(1);
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == F_DIV)
            begin
                step_reg <= step_reg + 1'b1;
            end
            else
            begin
                step_reg <= '0;
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_RANKS_IN_USE:   ranks_reg    <= cfg_data[RANKS_W-1:0];
                    CFG_EXPERTS_IN_USE: experts_reg  <= cfg_data[EXPERTS_W-1:0];
                    CFG_EXPERTS_PER_RK: per_rank_reg <= cfg_data[EXPERTS_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // Divider datapath and the held operation.
    always_ff @(posedge clk)
    begin
        if ((state_reg == F_IDLE) && accept && !is_direct)
        begin
            num_reg       <= items.expert_choice[IDX_W-1:0];
            rem_reg       <= '0;
            op_reg.cmd    <= CMD_ROUTE;
            op_reg.last   <= items.last_of_token;
            op_reg.expert <= items.expert_choice[IDX_W-1:0];
            op_reg.apply  <= 1'b0;
            op_reg.err    <= 1'b0;
            op_reg.index  <= '0;
        end
        else if (state_reg == F_DIV)
        begin
            num_reg <= quot;
            rem_reg <= rem_new[IDX_W-1:0];
            if (last_step)
            begin
                op_reg.apply <= !div_err;
                op_reg.err   <= div_err;
                op_reg.index <= quot;
            end
        end
    end

endmodule

// File: src/mdlc_back.sv
// Back part: carries out classified operations on the expert tally memory,
// the rank tallies and the token state, and holds the result register.
// Depends on mdlc_pkg and mdlc_out_if.
module mdlc_back #(
    parameter int MAX_EXPERTS = mdlc_pkg::DEF_MAX_EXPERTS,
    parameter int MAX_RANKS   = mdlc_pkg::DEF_MAX_RANKS,
    parameter int COUNT_BITS  = mdlc_pkg::DEF_COUNT_BITS
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   op_valid,
    output logic                   op_ready,
    input  mdlc_pkg::mdlc_op_t     op,
    mdlc_out_if.source             results,
    output mdlc_pkg::mdlc_status_t status
);
    import mdlc_pkg::*;

    localparam int EIDX_W = $clog2(MAX_EXPERTS);
    localparam int RIDX_W = (MAX_RANKS > 1) ? $clog2(MAX_RANKS) : 1;
    localparam logic [MAX_RANKS-1:0] RANK_ONE = 1;

    typedef enum logic [2:0] {
        B_SWEEP = 3'b001,
        B_IDLE  = 3'b010,
        B_EXEC  = 3'b100
    } back_state_t;

    back_state_t              state_reg;
    back_state_t              state_next;
    logic [EIDX_W-1:0]        sweep_reg;
    mdlc_op_t                 op_reg;
    logic [COUNT_BITS-1:0]    tally_mem [MAX_EXPERTS];
    logic [COUNT_BITS-1:0]    mem_q_reg;
    logic [COUNT_BITS-1:0]    rank_reg [MAX_RANKS];
    logic [MAX_RANKS-1:0]     seen_reg;
    logic                     err_reg;
    logic [ORD_W-1:0]         tok_reg;
    logic                     out_valid_reg;
    mdlc_kind_t               kind_reg;
    logic [ORD_W-1:0]         ord_reg;
    logic [MASK_W-1:0]        mask_reg;
    logic [CNT_W-1:0]         count_reg;
    logic                     bad_reg;

    logic                     pop;
    logic [IDX_W-1:0]         rd_index;
    logic [RIDX_W-1:0]        ridx;
    logic [COUNT_BITS-1:0]    rank_cur;
    logic                     needs_result;
    logic                     go;
    logic                     sweep_done;
    logic                     mem_we;
    logic [EIDX_W-1:0]        mem_waddr;
    logic [COUNT_BITS-1:0]    mem_wdata;
    logic [MAX_RANKS-1:0]     rank_bit;
    logic [MAX_RANKS-1:0]     seen_now;
    logic                     err_now;
    logic                     bump_rank;

    function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
        return (&v) ? v : v + 1'b1;
    endfunction

    function automatic logic [CNT_W-1:0] report(input logic [COUNT_BITS-1:0] v);
        return (32'(v) > 32'({CNT_W{1'b1}})) ? {CNT_W{1'b1}} : CNT_W'(v);
    endfunction

    assign op_ready = (state_reg == B_IDLE);
    assign pop      = op_valid && op_ready;
    assign rd_index = (op.cmd == CMD_ROUTE) ? op.expert : op.index;

    // Decode of the operation under way.
    assign ridx         = RIDX_W'(op_reg.index);
    assign rank_cur     = rank_reg[ridx];
    assign rank_bit     = RANK_ONE << ridx;
    assign bump_rank    = op_reg.apply && !seen_reg[ridx];
    assign seen_now     = op_reg.apply ? (seen_reg | rank_bit) : seen_reg;
    assign err_now      = err_reg | op_reg.err;
    assign needs_result = (op_reg.cmd != CMD_CLEAR) &&
                          !((op_reg.cmd == CMD_ROUTE) && !op_reg.last);
    assign go           = (state_reg == B_EXEC) &&
                          (!needs_result || !out_valid_reg || results.ready);
    assign sweep_done   = (sweep_reg == EIDX_W'(MAX_EXPERTS - 1));

    // Tally memory write port: clearing pass or saturating update.
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = sweep_reg;
        mem_wdata = '0;
        if (state_reg == B_SWEEP)
        begin
            mem_we = 1'b1;
        end
        else if (go && (op_reg.cmd == CMD_ROUTE) && op_reg.apply)
        begin
            mem_we    = 1'b1;
            mem_waddr = EIDX_W'(op_reg.expert);
            mem_wdata = sat_inc(mem_q_reg);
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            B_SWEEP:
            begin
                if (sweep_done)
                begin
                    state_next = B_IDLE;
                end
            end
            B_IDLE:
            begin
                if (pop)
                begin
                    state_next = B_EXEC;
                end
            end
            B_EXEC:
            begin
                if (go)
                begin
                    state_next = (op_reg.cmd == CMD_CLEAR) ? B_SWEEP : B_IDLE;
                end
            end
            default:
            begin
                state_next = B_SWEEP;
            end
        endcase
    end

    // Tally memory with registered read data.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            tally_mem[mem_waddr] <= mem_wdata;
        end
        if (pop)
        begin
            mem_q_reg <= tally_mem[EIDX_W'(rd_index)];
        end
    end

    // Control state, rank tallies and token state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_SWEEP;
            sweep_reg     <= '0;
            seen_reg      <= '0;
            err_reg       <= 1'b0;
            tok_reg       <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < MAX_RANKS; i++)
            begin
                rank_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == B_SWEEP)
            begin
                sweep_reg <= sweep_done ? '0 : sweep_reg + 1'b1;
            end
            if (go && needs_result)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (results.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (go)
            begin
                case (op_reg.cmd)
                    CMD_ROUTE:
                    begin
                        if (bump_rank)
                        begin
                            rank_reg[ridx] <= sat_inc(rank_cur);
                        end
                        if (op_reg.last)
                        begin
                            tok_reg  <= tok_reg + 1'b1;
                            seen_reg <= '0;
                            err_reg  <= 1'b0;
                        end
                        else
                        begin
                            seen_reg <= seen_now;
                            err_reg  <= err_now;
                        end
                    end
                    CMD_CLEAR:
                    begin
                        tok_reg  <= '0;
                        seen_reg <= '0;
                        err_reg  <= 1'b0;
                        sweep_reg <= '0;
                        for (int i = 0; i < MAX_RANKS; i++)
                        begin
                            rank_reg[i] <= '0;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // Operation register and result payload.
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            op_reg <= op;
        end
        if (go && needs_result)
        begin
            unique case (op_reg.cmd)
                CMD_ROUTE:
                begin
                    kind_reg  <= KIND_MASK;
                    ord_reg   <= tok_reg;
                    mask_reg  <= MASK_W'(seen_now);
                    count_reg <= '0;
                    bad_reg   <= err_now;
                end
                CMD_READ_EXPERT:
                begin
                    kind_reg  <= KIND_EXPERT;
                    ord_reg   <= '0;
                    mask_reg  <= '0;
                    count_reg <= op_reg.err ? '0 : report(mem_q_reg);
                    bad_reg   <= op_reg.err;
                end
                CMD_READ_RANK:
                begin
                    kind_reg  <= KIND_RANK;
                    ord_reg   <= '0;
                    mask_reg  <= '0;
                    count_reg <= op_reg.err ? '0 : report(rank_cur);
                    bad_reg   <= op_reg.err;
                end
                CMD_CLEAR:
                begin
                    kind_reg  <= KIND_MASK;
                    ord_reg   <= '0;
                    mask_reg  <= '0;
                    count_reg <= '0;
                    bad_reg   <= op_reg.err;
                end
            endcase
        end
    end

    // Result channel and status.
    assign results.valid         = out_valid_reg;
    assign results.result_kind   = kind_reg;
    assign results.token_ordinal = ord_reg;
    assign results.rank_mask     = mask_reg;
    assign results.count_value   = count_reg;
    assign results.bad_index     = bad_reg;

    assign status.sweeping = (state_reg == B_SWEEP);
    assign status.stalled  = (state_reg == B_EXEC) && needs_result && !go;

endmodule

// File: src/moe_dispatch_layout_counter.sv
// Channel     | Dir | Handshake        | Beat contents
// items       | in  | valid/ready      | cmd, expert_choice, last_of_token, read_index
// results     | out | valid/ready      | result_kind, token_ordinal, rank_mask,
//             |     |                  | count_value, bad_index
// cfg         | in  | cfg_we, no ready | cfg_index, cfg_data
//
// A route beat with a non-negative choice passes the front in order: accept, eight
// steps of the bit-serial rank divider, and the push into the queue.
// Other beats enter the queue in the cycle they are accepted. The back pops each
// operation with a registered tally read and finishes it in its execute state, taking
// no new operation before that. After reset and after every clear command, the back sweeps
// all MAX_EXPERTS tally memory entries and no input beat is accepted meanwhile.
// A stalled result register holds the back; the front fills the queue until full.
`include "assert_macros.svh"

module moe_dispatch_layout_counter #(
    parameter int MAX_EXPERTS = mdlc_pkg::DEF_MAX_EXPERTS,
    parameter int MAX_RANKS   = mdlc_pkg::DEF_MAX_RANKS,
    parameter int COUNT_BITS  = mdlc_pkg::DEF_COUNT_BITS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    mdlc_in_if.sink                         items,
    mdlc_out_if.source                      results,
    input  logic                            cfg_we,
    input  logic [mdlc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mdlc_pkg::CFG_DATA_W-1:0] cfg_data
);
    import mdlc_pkg::*;

    logic         front_valid;
    logic         front_ready;
    mdlc_op_t     front_op;
    logic         back_valid;
    logic         back_ready;
    mdlc_op_t     back_op;
    mdlc_status_t status;

    // Front: configuration, accept and classify.
    mdlc_front #(
        .MAX_EXPERTS (MAX_EXPERTS),
        .MAX_RANKS   (MAX_RANKS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .items     (items),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .status    (status),
        .op_valid  (front_valid),
        .op_ready  (front_ready),
        .op        (front_op)
    );

    // Queue between the two parts.
    mdlc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .push_op    (front_op),
        .pop_valid  (back_valid),
        .pop_ready  (back_ready),
        .pop_op     (back_op)
    );

    // Back: tallies, token state and result register.
    mdlc_back #(
        .MAX_EXPERTS (MAX_EXPERTS),
        .MAX_RANKS   (MAX_RANKS),
        .COUNT_BITS  (COUNT_BITS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .op_valid (back_valid),
        .op_ready (back_ready),
        .op       (back_op),
        .results  (results),
        .status   (status)
    );

    // The clearing pass blocks new input beats.
    `MDLC_ASSERT_IMP(a_sweep_blocks_input, clk, rst_n, status.sweeping, !items.ready)
    // A stalled back means a result is waiting and not taken.
    `MDLC_ASSERT_IMP(a_stall_has_result, clk, rst_n, status.stalled, results.valid && !results.ready)
    // No result appears while the tally memory is being cleared.
    `MDLC_ASSERT_NEXT(a_no_result_in_sweep, clk, rst_n, status.sweeping && !results.valid, !results.valid)
    // Count results carry no ordinal and no mask.
    `MDLC_ASSERT_IMP(a_count_fields_zero, clk, rst_n, results.valid && results.result_kind != KIND_MASK, results.token_ordinal == '0 && results.rank_mask == '0)

endmodule

// File: verif/moe_dispatch_layout_counter_tb.sv
// Self-checking testbench for the expert-dispatch layout counter.
// Depends on mdlc_pkg, the mdlc_in_if/mdlc_out_if channel interfaces and the RTL top.
// A scoreboard class tracks tallies and token state and checks every result beat.
module moe_dispatch_layout_counter_tb;
    import mdlc_pkg::*;

    localparam int EXPERT_SLOTS = DEF_MAX_EXPERTS;
    localparam int RANK_SLOTS   = DEF_MAX_RANKS;
    // The tally width equals the reported count width, so both saturate at all ones.
    localparam logic [CNT_W-1:0] TALLY_MAX = '1;
    // Register index past the end of the register list; writes to it are ignored.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
    localparam int REPORT_LIMIT    = 10;
    localparam int SETTLE_CYCLES   = 320;
    localparam int STALL_LIMIT     = 4000;
    localparam int PHASE_BEATS     = 155;

    typedef struct packed {
        mdlc_kind_t        kind;
        logic [ORD_W-1:0]  ordinal;
        logic [MASK_W-1:0] mask;
        logic [CNT_W-1:0]  count;
        logic              bad;
    } layout_report_t;

    // Shadow of the counter state and the queue of result beats still owed by the block.
    class layout_tracker;
        logic [CNT_W-1:0]     expert_tally [EXPERT_SLOTS];
        logic [CNT_W-1:0]     rank_tally [RANK_SLOTS];
        logic [MASK_W-1:0]    ranks_touched;
        logic [ORD_W-1:0]     token_number;
        logic                 token_bad;
        logic [RANKS_W-1:0]   ranks_cfg;
        logic [EXPERTS_W-1:0] experts_cfg;
        logic [EXPERTS_W-1:0] per_rank_cfg;
        layout_report_t       pending_reports [$];
        int                   mismatches;

        function new();
            clear_tallies();
            ranks_cfg    = 1;
            experts_cfg  = 1;
            per_rank_cfg = 1;
            mismatches   = 0;
        endfunction

        function void clear_tallies();
            foreach (expert_tally[i]) expert_tally[i] = '0;
            foreach (rank_tally[i]) rank_tally[i] = '0;
            ranks_touched = '0;
            token_number  = '0;
            token_bad     = 1'b0;
        endfunction

        function void write_register(logic [CFG_IDX_W-1:0] index,
                                     logic [CFG_DATA_W-1:0] value);
            case (index)
                CFG_RANKS_IN_USE:   ranks_cfg    = value[RANKS_W-1:0];
                CFG_EXPERTS_IN_USE: experts_cfg  = value[EXPERTS_W-1:0];
                CFG_EXPERTS_PER_RK: per_rank_cfg = value[EXPERTS_W-1:0];
                default: ;
            endcase
        endfunction

        // Apply one accepted input beat and queue the result beat it causes, if any.
        function void take_beat(mdlc_cmd_t cmd, logic [CHOICE_W-1:0] choice, logic last,
                                logic [IDX_W-1:0] idx);
            int unsigned    expert;
            int unsigned    rank;
            int unsigned    divisor;
            layout_report_t rep;
            rep = '0;
            case (cmd)
                CMD_ROUTE:
                begin
                    // A set sign bit means the slot holds no expert.
                    if (!choice[CHOICE_W-1])
                    begin
                        expert  = choice[IDX_W-1:0];
                        divisor = (per_rank_cfg == 0) ? 1 : per_rank_cfg;
                        rank    = expert / divisor;
                        if (expert >= experts_cfg || expert >= EXPERT_SLOTS ||
                            rank >= ranks_cfg || rank >= RANK_SLOTS)
                            token_bad = 1'b1;
                        else
                        begin
                            if (expert_tally[expert] != TALLY_MAX)
                                expert_tally[expert] = expert_tally[expert] + 1'b1;
                            if (!ranks_touched[rank])
                            begin
                                if (rank_tally[rank] != TALLY_MAX)
                                    rank_tally[rank] = rank_tally[rank] + 1'b1;
                                ranks_touched[rank] = 1'b1;
                            end
                        end
                    end
                    if (last)
                    begin
                        rep.kind    = KIND_MASK;
                        rep.ordinal = token_number;
                        rep.mask    = ranks_touched;
                        rep.bad     = token_bad;
                        pending_reports.push_back(rep);
                        token_number  = token_number + 1'b1;
                        ranks_touched = '0;
                        token_bad     = 1'b0;
                    end
                end
                CMD_READ_EXPERT:
                begin
                    rep.kind = KIND_EXPERT;
                    if (idx < experts_cfg && idx < EXPERT_SLOTS)
                        rep.count = expert_tally[idx];
                    else
                        rep.bad = 1'b1;
                    pending_reports.push_back(rep);
                end
                CMD_READ_RANK:
                begin
                    rep.kind = KIND_RANK;
                    if (idx < ranks_cfg && idx < RANK_SLOTS)
                        rep.count = rank_tally[idx];
                    else
                        rep.bad = 1'b1;
                    pending_reports.push_back(rep);
                end
                default: clear_tallies();
            endcase
        endfunction

        // Compare one accepted result beat with the oldest owed beat.
        function void match_report(layout_report_t seen);
            layout_report_t want;
            if (pending_reports.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("unexpected result beat: kind %0d ordinal %0d mask %h count %0d",
                             seen.kind, seen.ordinal, seen.mask, seen.count);
            end
            else
            begin
                want = pending_reports.pop_front();
                if (want !== seen)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display({"result mismatch (expected/actual): kind %0d/%0d ",
                                  "ordinal %0d/%0d mask %h/%h count %0d/%0d bad %0d/%0d"},
                                 want.kind, seen.kind, want.ordinal, seen.ordinal,
                                 want.mask, seen.mask, want.count, seen.count,
                                 want.bad, seen.bad);
                end
            end
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    src_idle_pct;
    int                    sink_idle_pct;
    int                    quiet_cycles = 0;
    int                    beats_sent = 0;
    layout_report_t        seen_rep;
    layout_tracker         sb;

    mdlc_in_if  item_ch ();
    mdlc_out_if result_ch ();

    moe_dispatch_layout_counter u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .items     (item_ch),
        .results   (result_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // Result side: check accepted beats and stall at random.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                seen_rep.kind    = mdlc_kind_t'(result_ch.result_kind);
                seen_rep.ordinal = result_ch.token_ordinal;
                seen_rep.mask    = result_ch.rank_mask;
                seen_rep.count   = result_ch.count_value;
                seen_rep.bad     = result_ch.bad_index;
                sb.match_report(seen_rep);
            end
            result_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
        end
        else
        begin
            result_ch.ready <= 1'b0;
        end
    end

    // Watchdog: too many cycles without any beat on either channel ends the run.
    always @(posedge clk)
    begin
        if (!rst_n || (item_ch.valid && item_ch.ready) ||
            (result_ch.valid && result_ch.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles < STALL_LIMIT)
            quiet_cycles <= quiet_cycles + 1;
        else
        begin
            $display("moe_dispatch_layout_counter_tb failed");
            $finish;
        end
    end

    // Present one input beat after a random gap and wait until it is accepted.
    task automatic send_beat(mdlc_cmd_t cmd, logic [CHOICE_W-1:0] choice, logic last,
                             logic [IDX_W-1:0] idx);
        while ($urandom_range(99) < src_idle_pct)
        begin
            item_ch.valid <= 1'b0;
            @(posedge clk);
        end
        item_ch.valid         <= 1'b1;
        item_ch.cmd           <= cmd;
        item_ch.expert_choice <= choice;
        item_ch.last_of_token <= last;
        item_ch.read_index    <= idx;
        @(posedge clk);
        while (!item_ch.ready) @(posedge clk);
        sb.take_beat(cmd, choice, last, idx);
        beats_sent++;
    endtask

    // Read beat: mostly an index in range, sometimes any index.
    task automatic send_read(mdlc_cmd_t cmd);
        int unsigned span;
        logic [IDX_W-1:0] idx;
        span = (cmd == CMD_READ_EXPERT) ? sb.experts_cfg : sb.ranks_cfg;
        if (span > EXPERT_SLOTS)
            span = EXPERT_SLOTS;
        if ($urandom_range(3) == 0)
            idx = IDX_W'($urandom_range(255));
        else
            idx = IDX_W'($urandom_range(span - 1));
        send_beat(cmd, CHOICE_W'($urandom), 1'($urandom_range(1)), idx);
    endtask

    // One token of top-k choices: mostly routable experts, some empty or out-of-range slots.
    task automatic send_token(int unsigned choices);
        int unsigned divisor;
        int unsigned span;
        int unsigned pick;
        logic [CHOICE_W-1:0] choice;
        divisor = (sb.per_rank_cfg == 0) ? 1 : sb.per_rank_cfg;
        span = sb.ranks_cfg * divisor;
        if (span > sb.experts_cfg)
            span = sb.experts_cfg;
        if (span > EXPERT_SLOTS)
            span = EXPERT_SLOTS;
        for (int i = 0; i < choices; i++)
        begin
            pick = $urandom_range(99);
            if (pick < 8)
                choice = CHOICE_W'(9'h100 | $urandom_range(255));
            else if (pick < 20)
                choice = CHOICE_W'($urandom_range(255));
            else
                choice = CHOICE_W'($urandom_range(span - 1));
            if ($urandom_range(19) == 0)
                send_read($urandom_range(1) ? CMD_READ_RANK : CMD_READ_EXPERT);
            send_beat(CMD_ROUTE, choice, (i == choices - 1), IDX_W'($urandom));
        end
    endtask

    // Wait until every owed result has arrived and the block has had time to go quiet.
    task automatic drain_and_settle();
        item_ch.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending_reports.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_cfg(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
        sb.write_register(index, value);
    endtask

    task automatic set_config(int unsigned ranks, int unsigned experts, int unsigned per_rank);
        write_cfg(CFG_RANKS_IN_USE, CFG_DATA_W'(ranks));
        write_cfg(CFG_EXPERTS_IN_USE, CFG_DATA_W'(experts));
        write_cfg(CFG_EXPERTS_PER_RK, CFG_DATA_W'(per_rank));
        write_cfg(CFG_SPARE, CFG_DATA_W'($urandom));
        cfg_we <= 1'b0;
    endtask

    // Random phase: well-formed tokens with reads, clears and stray choices mixed in.
    task automatic run_phase(int unsigned ranks, int unsigned experts, int unsigned per_rank,
                             int src_idle, int sink_idle);
        int target;
        int unsigned pick;
        drain_and_settle();
        set_config(ranks, experts, per_rank);
        src_idle_pct  = src_idle;
        sink_idle_pct = sink_idle;
        target = beats_sent + PHASE_BEATS;
        while (beats_sent < target)
        begin
            pick = $urandom_range(99);
            if (pick < 8)
                send_read(CMD_READ_EXPERT);
            else if (pick < 15)
                send_read(CMD_READ_RANK);
            else if (pick < 16)
                send_beat(CMD_CLEAR, CHOICE_W'($urandom), 1'($urandom_range(1)),
                          IDX_W'($urandom));
            else if (pick < 20)
                send_beat(CMD_ROUTE, CHOICE_W'($urandom), 1'($urandom_range(1)),
                          IDX_W'($urandom));
            else
                send_token($urandom_range(1, 8));
        end
    endtask

    initial
    begin
        sb = new();
        src_idle_pct  = 37;
        sink_idle_pct = 70;
        rst_n                 <= 1'b0;
        cfg_we                <= 1'b0;
        cfg_index             <= CFG_RANKS_IN_USE;
        cfg_data              <= '0;
        item_ch.valid         <= 1'b0;
        item_ch.cmd           <= CMD_ROUTE;
        item_ch.expert_choice <= '0;
        item_ch.last_of_token <= 1'b0;
        item_ch.read_index    <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: three ranks of four experts out of sixteen, so experts 12..15 land
        // on a rank that is not in use.
        set_config(3, 16, 4);
        send_beat(CMD_READ_EXPERT, 9'd0, 1'b0, 8'd0);
        send_beat(CMD_READ_RANK, 9'd0, 1'b0, 8'd0);
        send_beat(CMD_ROUTE, 9'd0, 1'b0, 8'd0);
        send_beat(CMD_ROUTE, 9'd5, 1'b0, 8'd0);
        // A second expert on an already used rank must not raise the rank count.
        send_beat(CMD_ROUTE, 9'd1, 1'b0, 8'd0);
        send_beat(CMD_ROUTE, 9'h1FF, 1'b1, 8'd0);
        // Rank out of range, expert out of range, then the widest positive choice.
        send_beat(CMD_ROUTE, 9'd13, 1'b0, 8'd0);
        send_beat(CMD_ROUTE, 9'd200, 1'b0, 8'd0);
        send_beat(CMD_ROUTE, 9'd255, 1'b1, 8'd255);
        // Tokens that hold no expert at all still finish.
        send_beat(CMD_ROUTE, 9'h1FF, 1'b1, 8'd0);
        send_beat(CMD_ROUTE, 9'h100, 1'b1, 8'd0);
        // Reads, including out-of-range indices and a stray last flag.
        send_beat(CMD_READ_EXPERT, 9'd0, 1'b1, 8'd0);
        send_beat(CMD_READ_EXPERT, 9'd0, 1'b0, 8'd255);
        send_beat(CMD_READ_RANK, 9'd0, 1'b0, 8'd15);
        send_beat(CMD_READ_RANK, 9'd0, 1'b0, 8'd1);
        send_beat(CMD_READ_RANK, 9'd0, 1'b0, 8'd3);
        // Clear with the last flag set finishes no token and restarts the ordinal.
        send_beat(CMD_CLEAR, 9'h1FF, 1'b1, 8'd255);
        send_beat(CMD_READ_EXPERT, 9'd0, 1'b0, 8'd0);
        send_beat(CMD_ROUTE, 9'd8, 1'b1, 8'd0);
        send_beat(CMD_READ_RANK, 9'd0, 1'b0, 8'd2);

        // Directed: a zero divisor acts as one, so each expert is its own rank.
        drain_and_settle();
        set_config(16, 256, 0);
        send_beat(CMD_ROUTE, 9'd15, 1'b1, 8'd0);
        send_beat(CMD_ROUTE, 9'd16, 1'b1, 8'd0);
        send_beat(CMD_READ_RANK, 9'd0, 1'b0, 8'd15);

        // Random phases over several layouts, the extremes among them.
        run_phase(16, 256, 16, 37, 70);
        run_phase(1, 1, 1, 37, 70);
        run_phase(16, 256, 256, 37, 70);
        run_phase(4, 64, 16, 70, 37);
        run_phase(5, 40, 0, 70, 37);
        run_phase(16, 128, 8, 70, 37);
        run_phase($urandom_range(1, 16), $urandom_range(1, 256), $urandom_range(1, 256), 0, 0);
        run_phase(3, 200, 100, 0, 0);
        run_phase(16, 255, 16, 0, 0);

        drain_and_settle();
        if (sb.mismatches == 0 && sb.pending_reports.size() == 0)
            $display("moe_dispatch_layout_counter_tb passed");
        else
            $display("moe_dispatch_layout_counter_tb failed");
        $finish;
    end

endmodule

// File: files.f
+incdir+src
src/mdlc_pkg.sv
src/mdlc_if.sv
src/mdlc_queue.sv
src/mdlc_front.sv
src/mdlc_back.sv
src/moe_dispatch_layout_counter.sv
verif/moe_dispatch_layout_counter_tb.sv
